// ===== hdl/kct_pkg.sv =====
// ----------------------------------------------------------------------------
// kct_pkg: shared types and codes of the keyed credit table
// Operation and status codes, stream widths, and the structs that run
// between the table cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

	localparam int KEY_W       = 64;
	localparam int QTY_W       = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_REGISTER = 2'd0,
		FUNC_RESERVE  = 2'd1,
		FUNC_RELEASE  = 2'd2,
		FUNC_QUERY    = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NOT_FOUND    = 3'd1,
		ST_INSUFFICIENT = 3'd2,
		ST_FULL         = 3'd3,
		ST_DUPLICATE    = 3'd4
	} status_t;

	// request broadcast to every cell in the completion cycle
	typedef struct packed {
		logic             adv;
		logic             ins;
		func_t            func;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
	} kct_req_t;

	// what one cell hands to its right-hand neighbor
	typedef struct packed {
		logic             valid;
		logic             pos;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] max;
		logic [QTY_W-1:0] avail;
	} kct_link_t;

	// per-cell result, all zero unless the cell holds the key
	typedef struct packed {
		logic             hit;
		logic             insuff;
		logic [QTY_W-1:0] avail;
		logic [QTY_W-1:0] max;
	} kct_res_t;

endpackage

`default_nettype wire

// ===== hdl/keyed_credit_table_unit.sv =====
// an accepted item waits in the s1 register while the cells register the key
// compare; the cells update or shift and the result enters the output
// register once it is free, one item at a time; a result waiting there does
// not block acceptance of the next item, only its completion
// reset: arst_n clears every cell valid bit and both valid flags; the table
// is empty at once, no clearing pass
// ----------------------------------------------------------------------------
// keyed_credit_table_unit: sorted key table with credit counters
// A row of cells kept in ascending key order; register, reserve, release
// and query requests on a stream input give one status item each.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_credit_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// func [1:0], key [65:2], qty [97:66], zero fill
	input  wire  [kct_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// status [2:0], avail_out [34:3], max_out [66:35], zero fill
	output logic [kct_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import kct_pkg::*;

	logic             s1_valid_q;
	func_t            func_s1;
	logic [KEY_W-1:0] key_s1;
	logic [QTY_W-1:0] qty_s1;

	logic                out_valid_q;
	status_t             status_q;
	logic [QTY_W-1:0]    avail_q;
	logic [QTY_W-1:0]    max_q;

	logic             accept;
	logic             adv;
	logic             full;
	logic             any_hit;
	logic             any_insuff;
	logic [QTY_W-1:0] sel_avail;
	logic [QTY_W-1:0] sel_max;

	kct_req_t  req;
	kct_link_t links [TABLE_DEPTH+1];
	kct_res_t  res   [TABLE_DEPTH];

	assign s_tready = !s1_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign adv      = s1_valid_q && (!out_valid_q || m_tready);

	assign links[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kct_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmp_en  (accept),
			.cmp_key (s_tdata[KEY_W+FUNC_W-1:FUNC_W]),
			.req     (req),
			.prev    (links[i]),
			.next    (links[i+1]),
			.res     (res[i])
		);
	end

	assign full = links[TABLE_DEPTH].valid;

	// at most one cell holds the key, so an or over the masked results selects it
	always_comb begin
		any_hit    = 1'b0;
		any_insuff = 1'b0;
		sel_avail  = '0;
		sel_max    = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			any_hit    = any_hit | res[i].hit;
			any_insuff = any_insuff | res[i].insuff;
			sel_avail  = sel_avail | res[i].avail;
			sel_max    = sel_max | res[i].max;
		end
	end

	assign req.adv  = adv;
	assign req.ins  = (func_s1 == FUNC_REGISTER) && !full && !any_hit;
	assign req.func = func_s1;
	assign req.key  = key_s1;
	assign req.qty  = qty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(s_tdata[FUNC_W-1:0]);
			key_s1  <= s_tdata[KEY_W+FUNC_W-1:FUNC_W];
			qty_s1  <= s_tdata[QTY_W+KEY_W+FUNC_W-1:KEY_W+FUNC_W];
		end
		if (adv) begin
			case (func_s1)
				FUNC_REGISTER: begin
					if (full) begin
						status_q <= ST_FULL;
						avail_q  <= '0;
						max_q    <= '0;
					end else if (any_hit) begin
						status_q <= ST_DUPLICATE;
						avail_q  <= sel_avail;
						max_q    <= sel_max;
					end else begin
						status_q <= ST_OK;
						avail_q  <= qty_s1;
						max_q    <= qty_s1;
					end
				end
				default: begin
					if (!any_hit) begin
						status_q <= ST_NOT_FOUND;
					end else if (any_insuff) begin
						status_q <= ST_INSUFFICIENT;
					end else begin
						status_q <= ST_OK;
					end
					avail_q <= sel_avail;
					max_q   <= sel_max;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-STATUS_W-2*QTY_W){1'b0}}, max_q, avail_q, status_q};

endmodule

`default_nettype wire

// ===== hdl/kct_cell.sv =====
// ----------------------------------------------------------------------------
// kct_cell: one slot of the sorted credit table
// Holds one key with its maximum and available quantity, compares against
// an incoming key, updates its own counter and shifts right on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cmp_en,
	input  wire [kct_pkg::KEY_W-1:0] cmp_key,
	input  wire kct_pkg::kct_req_t   req,
	input  wire kct_pkg::kct_link_t  prev,
	output kct_pkg::kct_link_t       next,
	output kct_pkg::kct_res_t        res
);
	import kct_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [QTY_W-1:0] max_q;
	logic [QTY_W-1:0] avail_q;
	logic             eq_q;
	logic             gt_q;

	logic             pos;
	logic             hit;
	logic             insuff;
	logic [QTY_W:0]   sum;
	logic [QTY_W-1:0] nav;

	// insert position lies at or before this cell
	assign pos    = !valid_q || gt_q;
	assign hit    = valid_q && eq_q;
	assign insuff = req.qty > avail_q;
	assign sum    = {1'b0, avail_q} + {1'b0, req.qty};

	always_comb begin
		case (req.func)
			FUNC_RESERVE: nav = insuff ? avail_q : avail_q - req.qty;
			FUNC_RELEASE: nav = (sum > {1'b0, max_q}) ? max_q : sum[QTY_W-1:0];
			default:      nav = avail_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.adv && req.ins) begin
			if (prev.pos) begin
				valid_q <= prev.valid;
			end else if (pos) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			eq_q <= key_q == cmp_key;
			gt_q <= key_q > cmp_key;
		end
		if (req.adv) begin
			if (req.ins) begin
				if (prev.pos) begin
					key_q   <= prev.key;
					max_q   <= prev.max;
					avail_q <= prev.avail;
				end else if (pos) begin
					key_q   <= req.key;
					max_q   <= req.qty;
					avail_q <= req.qty;
				end
			end else if (hit) begin
				avail_q <= nav;
			end
		end
	end

	assign next.valid = valid_q;
	assign next.pos   = pos;
	assign next.key   = key_q;
	assign next.max   = max_q;
	assign next.avail = avail_q;

	assign res.hit    = hit;
	assign res.insuff = hit && (req.func == FUNC_RESERVE) && insuff;
	assign res.avail  = hit ? nav : '0;
	assign res.max    = hit ? max_q : '0;

endmodule

`default_nettype wire

// ===== hdl/kct_checker.sv =====
// ----------------------------------------------------------------------------
// kct_checker: port-level checks of the keyed credit table
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tvalid,
	input wire                             s_tready,
	input wire [kct_pkg::IN_TDATA_W-1:0]   s_tdata,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [kct_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import kct_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_DUPLICATE)
		else $error("status code out of range");

	// available never exceeds the maximum in any reported entry
	a_avail_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:3] <= m_tdata[66:35])
		else $error("available above maximum");

	// nothing reported for an absent entry
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == ST_NOT_FOUND || m_tdata[2:0] == ST_FULL)
		|-> m_tdata[66:3] == '0)
		else $error("quantities reported for an absent entry");

	// upper fill bits of the input are not looked at
	logic unused_fill;
	assign unused_fill = ^s_tdata[IN_TDATA_W-1:QTY_W+KEY_W+FUNC_W];

endmodule

bind keyed_credit_table_unit kct_checker u_kct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
